// ----- rtl/core/midi_byte_stream_parser_top_assert.svh -----
// Assertion macros for the MIDI byte stream parser.
`ifndef MIDI_BYTE_STREAM_PARSER_TOP_ASSERT_SVH
`define MIDI_BYTE_STREAM_PARSER_TOP_ASSERT_SVH
`ifndef SYNTHESIS
// Same-cycle implication, checked outside reset.
`define MBSP_ASSERT_HOLDS(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
// Next-cycle implication, checked outside reset.
`define MBSP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`else
`define MBSP_ASSERT_HOLDS(label, clk, rst, ante, cons, msg)
`define MBSP_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif
`endif

// ----- rtl/core/mbsp_pkg.sv -----
// Shared types and constants of the MIDI byte stream parser.
package mbsp_pkg;

   localparam int PORT_W        = 3;
   localparam int BYTE_W        = 8;
   localparam int LEN_W         = 2;
   localparam int CHAN_W        = 4;
   localparam int NUM_PORTS_DEF = 8;
   localparam int MAX_PORTS     = 1 << PORT_W;

   // Per-port parse mode
   typedef enum logic [2:0] {
      MODE_IDLE  = 3'd0,
      MODE_DATA0 = 3'd1,
      MODE_DATA1 = 3'd2,
      MODE_SX0   = 3'd3,
      MODE_SX1   = 3'd4
   } mode_type;

   // Channel status codes (channel nibble zero)
   localparam logic [7:0] ST_NOTE_OFF = 8'h80;
   localparam logic [7:0] ST_NOTE_ON  = 8'h90;
   localparam logic [7:0] ST_POLY_AT  = 8'hA0;
   localparam logic [7:0] ST_CTRL     = 8'hB0;
   localparam logic [7:0] ST_PROG     = 8'hC0;
   localparam logic [7:0] ST_CHAN_AT  = 8'hD0;
   localparam logic [7:0] ST_BEND     = 8'hE0;

   // System common codes
   localparam logic [7:0] ST_SYSEX    = 8'hF0;
   localparam logic [7:0] ST_QFRAME   = 8'hF1;
   localparam logic [7:0] ST_SONG_POS = 8'hF2;
   localparam logic [7:0] ST_SONG_SEL = 8'hF3;
   localparam logic [7:0] ST_TUNE     = 8'hF6;
   localparam logic [7:0] ST_EOX      = 8'hF7;

   // Realtime codes
   localparam logic [7:0] RT_CLOCK    = 8'hF8;
   localparam logic [7:0] RT_START    = 8'hFA;
   localparam logic [7:0] RT_CONT     = 8'hFB;
   localparam logic [7:0] RT_STOP     = 8'hFC;
   localparam logic [7:0] RT_SENSE    = 8'hFE;
   localparam logic [7:0] RT_RESET    = 8'hFF;

   localparam logic [7:0] HI_MASK     = 8'hF0;
   localparam logic [7:0] VEL_RELEASE = 8'h40;

   // Message lengths
   localparam logic [LEN_W-1:0] LEN_NONE = 2'd0;
   localparam logic [LEN_W-1:0] LEN_1    = 2'd1;
   localparam logic [LEN_W-1:0] LEN_2    = 2'd2;
   localparam logic [LEN_W-1:0] LEN_3    = 2'd3;

   // Parse context held per port
   typedef struct packed {
      mode_type            mode;
      logic [BYTE_W-1:0]   status;
      logic [CHAN_W-1:0]   channel;
      logic [BYTE_W-1:0]   first_data;
   } ctx_type;

   localparam ctx_type CTX_RESET = '{MODE_IDLE, 8'h00, 4'h0, 8'h00};

   // One assembled message
   typedef struct packed {
      logic [PORT_W-1:0]   port;
      logic [LEN_W-1:0]    len;
      logic [BYTE_W-1:0]   status;
      logic [BYTE_W-1:0]   data0;
      logic [BYTE_W-1:0]   data1;
   } msg_type;

endpackage

// ----- rtl/core/mbsp_req_if.sv -----
// Byte input channel of the MIDI byte stream parser.
interface mbsp_req_if;
   logic                          valid;
   logic                          ready;
   logic [mbsp_pkg::PORT_W-1:0]   port;
   logic [mbsp_pkg::BYTE_W-1:0]   rx_byte;

   modport source (output valid, output port, output rx_byte, input ready);
   modport sink   (input valid, input port, input rx_byte, output ready);
endinterface

// ----- rtl/core/mbsp_rsp_if.sv -----
// Message output channel of the MIDI byte stream parser.
interface mbsp_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [mbsp_pkg::PORT_W-1:0]   msg_port;
   logic [mbsp_pkg::LEN_W-1:0]    msg_len;
   logic [mbsp_pkg::BYTE_W-1:0]   msg_status;
   logic [mbsp_pkg::BYTE_W-1:0]   msg_data0;
   logic [mbsp_pkg::BYTE_W-1:0]   msg_data1;

   modport source (output valid, output msg_port, output msg_len, output msg_status,
                   output msg_data0, output msg_data1, input ready);
   modport sink   (input valid, input msg_port, input msg_len, input msg_status,
                   input msg_data0, input msg_data1, output ready);
endinterface

// ----- rtl/core/mbsp_ctx_store.sv -----
// Per-port parse context registers with one read and one write port.
module mbsp_ctx_store #(
   parameter int NUM_PORTS = mbsp_pkg::NUM_PORTS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [mbsp_pkg::PORT_W-1:0]   rd_port,
   output mbsp_pkg::ctx_type             rd_ctx,
   input  logic                          wr_en,
   input  logic [mbsp_pkg::PORT_W-1:0]   wr_port,
   input  mbsp_pkg::ctx_type             wr_ctx
);
   import mbsp_pkg::*;

   // Only ports reachable by the port field need a context
   localparam int CTX_DEPTH = (NUM_PORTS < MAX_PORTS) ? NUM_PORTS : MAX_PORTS;
   localparam int CTX_IW    = (CTX_DEPTH > 1) ? $clog2(CTX_DEPTH) : 1;

   ctx_type             ctx_ff [CTX_DEPTH];
   logic [CTX_IW-1:0]   rd_idx;
   logic [CTX_IW-1:0]   wr_idx;

   assign rd_idx = rd_port[CTX_IW-1:0];
   assign wr_idx = wr_port[CTX_IW-1:0];

   // Read; unreachable entries read as reset context
   always_comb begin
      rd_ctx = CTX_RESET;
      if (int'(rd_port) < CTX_DEPTH) begin
         rd_ctx = ctx_ff[rd_idx];
      end
   end

   // Context update
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < CTX_DEPTH; i++) begin
            ctx_ff[i] <= CTX_RESET;
         end
      end else if (wr_en && (int'(wr_port) < CTX_DEPTH)) begin
         ctx_ff[wr_idx] <= wr_ctx;
      end
   end

endmodule

// ----- rtl/core/mbsp_step.sv -----
// Parse step: next context and completed message for one byte.
module mbsp_step (
   input  logic [mbsp_pkg::PORT_W-1:0]   port,
   input  logic [mbsp_pkg::BYTE_W-1:0]   rx_byte,
   input  mbsp_pkg::ctx_type             ctx,
   output mbsp_pkg::ctx_type             nxt_ctx,
   output logic                          emit,
   output mbsp_pkg::msg_type             msg
);
   import mbsp_pkg::*;

   logic                is_status;
   logic                is_system;
   logic [BYTE_W-1:0]   st_ch;

   assign is_status = rx_byte[7];
   assign is_system = (rx_byte & HI_MASK) == HI_MASK;
   assign st_ch     = ctx.status | {4'h0, ctx.channel};

   // Next parse context
   always_comb begin
      nxt_ctx = ctx;
      if (is_status) begin
         if (is_system) begin
            case (rx_byte) inside
               ST_SONG_POS, ST_SONG_SEL: begin
                  nxt_ctx.channel = '0;
                  nxt_ctx.status  = rx_byte;
                  nxt_ctx.mode    = MODE_DATA0;
               end
               ST_SYSEX: begin
                  nxt_ctx.channel = '0;
                  nxt_ctx.status  = rx_byte;
                  nxt_ctx.mode    = MODE_SX0;
               end
               ST_QFRAME, ST_TUNE, RT_CLOCK, RT_START, RT_CONT, RT_STOP, RT_SENSE: begin
               end
               ST_EOX: begin
                  nxt_ctx.mode = MODE_IDLE;
               end
               // system reset and undefined system bytes
               default: begin
                  nxt_ctx.status  = '0;
                  nxt_ctx.channel = '0;
                  nxt_ctx.mode    = MODE_IDLE;
               end
            endcase
         end else begin
            nxt_ctx.channel = rx_byte[3:0];
            nxt_ctx.status  = rx_byte & HI_MASK;
            nxt_ctx.mode    = MODE_DATA0;
         end
      end else begin
         unique case (ctx.mode)
            MODE_DATA0: begin
               nxt_ctx.first_data = rx_byte;
               if (ctx.status == ST_SONG_SEL) begin
                  nxt_ctx.status  = '0;
                  nxt_ctx.channel = '0;
                  nxt_ctx.mode    = MODE_IDLE;
               end else if (ctx.status != ST_PROG && ctx.status != ST_CHAN_AT) begin
                  nxt_ctx.mode = MODE_DATA1;
               end
            end
            MODE_DATA1: begin
               if (ctx.status == ST_SONG_POS) begin
                  nxt_ctx.status  = '0;
                  nxt_ctx.channel = '0;
                  nxt_ctx.mode    = MODE_IDLE;
               end else begin
                  nxt_ctx.mode = MODE_DATA0;
               end
            end
            MODE_SX0: begin
               nxt_ctx.first_data = rx_byte;
               nxt_ctx.mode       = MODE_SX1;
            end
            MODE_SX1: begin
               nxt_ctx.mode = MODE_IDLE;
            end
            // idle: data byte opens a SysEx continuation chunk
            default: begin
               nxt_ctx.status = rx_byte;
               nxt_ctx.mode   = MODE_SX0;
            end
         endcase
      end
   end

   // Completed message
   always_comb begin
      emit       = 1'b0;
      msg.port   = port;
      msg.len    = LEN_NONE;
      msg.status = '0;
      msg.data0  = '0;
      msg.data1  = '0;
      if (is_status) begin
         if (is_system) begin
            case (rx_byte) inside
               ST_TUNE, RT_CLOCK, RT_START, RT_CONT, RT_STOP, RT_SENSE, RT_RESET: begin
                  emit       = 1'b1;
                  msg.len    = LEN_1;
                  msg.status = rx_byte;
               end
               ST_EOX: begin
                  emit = 1'b1;
                  if (ctx.mode == MODE_SX1) begin
                     msg.len    = LEN_3;
                     msg.status = ctx.status;
                     msg.data0  = ctx.first_data;
                     msg.data1  = ST_EOX;
                  end else if (ctx.mode == MODE_SX0) begin
                     msg.len    = LEN_2;
                     msg.status = ctx.status;
                     msg.data0  = ST_EOX;
                  end else begin
                     msg.len    = LEN_1;
                     msg.status = ST_EOX;
                  end
               end
               default: begin
               end
            endcase
         end else if (ctx.mode == MODE_SX0 || ctx.mode == MODE_SX1) begin
            // channel status breaks SysEx: close it with a lone end byte
            emit       = 1'b1;
            msg.len    = LEN_1;
            msg.status = ST_EOX;
         end
      end else begin
         unique case (ctx.mode)
            MODE_DATA0: begin
               if (ctx.status == ST_SONG_SEL) begin
                  emit       = 1'b1;
                  msg.len    = LEN_2;
                  msg.status = ST_SONG_SEL;
                  msg.data0  = rx_byte;
               end else if (ctx.status == ST_PROG || ctx.status == ST_CHAN_AT) begin
                  emit       = 1'b1;
                  msg.len    = LEN_2;
                  msg.status = st_ch;
                  msg.data0  = rx_byte;
               end
            end
            MODE_DATA1: begin
               msg.len   = LEN_3;
               msg.data0 = ctx.first_data;
               msg.data1 = rx_byte;
               case (ctx.status) inside
                  ST_SONG_POS: begin
                     emit       = 1'b1;
                     msg.status = ST_SONG_POS;
                  end
                  ST_NOTE_ON: begin
                     emit = 1'b1;
                     if (rx_byte == '0) begin
                        // note-on at zero velocity is a release
                        msg.status = ST_NOTE_OFF | {4'h0, ctx.channel};
                        msg.data1  = VEL_RELEASE;
                     end else begin
                        msg.status = st_ch;
                     end
                  end
                  ST_NOTE_OFF, ST_POLY_AT, ST_CTRL, ST_BEND: begin
                     emit       = 1'b1;
                     msg.status = st_ch;
                  end
                  default: begin
                     msg.len   = LEN_NONE;
                     msg.data0 = '0;
                     msg.data1 = '0;
                  end
               endcase
            end
            MODE_SX1: begin
               emit       = 1'b1;
               msg.len    = LEN_3;
               msg.status = ctx.status;
               msg.data0  = ctx.first_data;
               msg.data1  = rx_byte;
            end
            default: begin
            end
         endcase
      end
   end

endmodule

// ----- rtl/core/midi_byte_stream_parser_top.sv -----
// Top level of the MIDI byte stream parser.
//
// req_chan carries one MIDI byte and the port it came in on; rsp_chan
// carries assembled messages (length 1 to 3, unused bytes zero). A byte
// transfer on req_chan yields zero or one message, in arrival order.
// Each port keeps its own running status, parse mode and held data byte;
// bytes on ports at or above NUM_PORTS are dropped without effect.
// Path: a byte is held in the input register while it is parsed; its
// message is then registered in the output register for rsp_chan.
// Throughput: one byte per cycle unless a message waits on a stalled
// rsp_chan; the parse of a byte is one context read, a short decode and
// a context write-back in the same cycle, so the next byte on the same
// port sees the updated context at once.
// When rsp_chan stalls, the finished message waits in the output register
// and one further byte is still taken into the input register; bytes that
// make no message keep flowing past a waiting one.
// Reset (synchronous, active high) empties both registers and puts every
// port back to idle with no running status.
`include "midi_byte_stream_parser_top_assert.svh"
module midi_byte_stream_parser_top #(
   parameter int NUM_PORTS = mbsp_pkg::NUM_PORTS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   mbsp_req_if.sink    req_chan,
   mbsp_rsp_if.source  rsp_chan
);
   import mbsp_pkg::*;

   logic                in_vld_ff;
   logic                in_vld_in;
   logic [PORT_W-1:0]   in_port_ff;
   logic [BYTE_W-1:0]   in_byte_ff;
   logic                out_vld_ff;
   logic                out_vld_in;
   msg_type             out_msg_ff;

   ctx_type             cur_ctx;
   ctx_type             nxt_ctx;
   msg_type             step_msg;
   logic                step_emit;
   logic                port_ok;
   logic                fire;
   logic                advance;
   logic                req_xfer;

   // Context storage
   mbsp_ctx_store #(
      .NUM_PORTS (NUM_PORTS)
   ) u_ctx_store (
      .clock   (clock),
      .reset   (reset),
      .rd_port (in_port_ff),
      .rd_ctx  (cur_ctx),
      .wr_en   (advance && port_ok),
      .wr_port (in_port_ff),
      .wr_ctx  (nxt_ctx)
   );

   // Parse logic
   mbsp_step u_step (
      .port    (in_port_ff),
      .rx_byte (in_byte_ff),
      .ctx     (cur_ctx),
      .nxt_ctx (nxt_ctx),
      .emit    (step_emit),
      .msg     (step_msg)
   );

   // Flow control
   assign port_ok  = int'(in_port_ff) < NUM_PORTS;
   assign fire     = step_emit && port_ok;
   assign advance  = in_vld_ff && (!fire || !out_vld_ff || rsp_chan.ready);
   assign req_chan.ready = !in_vld_ff || advance;
   assign req_xfer = req_chan.valid && req_chan.ready;

   always_comb begin
      in_vld_in = in_vld_ff;
      if (req_xfer) begin
         in_vld_in = 1'b1;
      end else if (advance) begin
         in_vld_in = 1'b0;
      end
   end

   assign out_vld_in = (advance && fire) || (out_vld_ff && !rsp_chan.ready);

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         in_vld_ff  <= in_vld_in;
         out_vld_ff <= out_vld_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         in_port_ff <= req_chan.port;
         in_byte_ff <= req_chan.rx_byte;
      end
      if (advance && fire) begin
         out_msg_ff <= step_msg;
      end
   end

   // Output drive
   assign rsp_chan.valid      = out_vld_ff;
   assign rsp_chan.msg_port   = out_msg_ff.port;
   assign rsp_chan.msg_len    = out_msg_ff.len;
   assign rsp_chan.msg_status = out_msg_ff.status;
   assign rsp_chan.msg_data0  = out_msg_ff.data0;
   assign rsp_chan.msg_data1  = out_msg_ff.data1;

   // Checks
   `MBSP_ASSERT_HOLDS(a_len_nonzero, clock, reset, rsp_chan.valid, rsp_chan.msg_len != LEN_NONE, "message with zero length")
   `MBSP_ASSERT_HOLDS(a_port_range, clock, reset, rsp_chan.valid, int'(rsp_chan.msg_port) < NUM_PORTS, "message on unused port")
   `MBSP_ASSERT_HOLDS(a_short_pad, clock, reset, rsp_chan.valid && rsp_chan.msg_len == LEN_1, rsp_chan.msg_data0 == '0 && rsp_chan.msg_data1 == '0, "one-byte message has nonzero data")
   `MBSP_ASSERT_NEXT(a_req_lands, clock, reset, req_xfer, in_vld_ff, "accepted byte not held")

endmodule

// ----- tb/tb_midi_byte_stream_parser_top.sv -----
// Self-checking testbench for the MIDI byte stream parser top level.
`timescale 1ns / 100ps
module tb_midi_byte_stream_parser_top;
   import mbsp_pkg::*;

   localparam int HALF_PERIOD = 6;
   localparam int DRAIN_CYCLES = 8;
   localparam logic [7:0] CHAN_CODES [7] = '{ST_NOTE_OFF, ST_NOTE_ON, ST_POLY_AT, ST_CTRL,
                                              ST_PROG, ST_CHAN_AT, ST_BEND};
   localparam logic [7:0] RT_CODES [5] = '{RT_CLOCK, RT_START, RT_CONT, RT_STOP, RT_SENSE};
   // System bytes with no defined meaning; they drop the port context
   localparam logic [7:0] UNDEF_CODES [4] = '{8'hF4, 8'hF5, 8'hF9, 8'hFD};

   logic clock;
   logic reset;

   mbsp_req_if req_chan ();
   mbsp_rsp_if rsp_chan ();

   midi_byte_stream_parser_top dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   // Parse context mirror, one entry per port
   mode_type          port_mode   [MAX_PORTS];
   logic [7:0]        port_status [MAX_PORTS];
   logic [3:0]        port_chan   [MAX_PORTS];
   logic [7:0]        port_first  [MAX_PORTS];

   msg_type pending_msgs [$];
   int      mismatch_count = 0;
   int      bytes_sent = 0;
   bit      src_fast = 0;
   bit      sink_fast = 0;
   int      sink_hold_cycles = 0;

   // Clock
   initial clock = 1'b0;
   always #(HALF_PERIOD) clock = ~clock;

   function automatic int draw_gap();
      return $urandom_range(0, 1) ? 0 : $urandom_range(0, 16);
   endfunction

   function automatic void clear_port(int p);
      port_status[p] = '0;
      port_chan[p]   = '0;
      port_mode[p]   = MODE_IDLE;
   endfunction

   // Advance one port's context by one byte; returns 1 when a message completes
   function automatic bit parse_byte(input logic [PORT_W-1:0] p, input logic [7:0] b,
                                     output msg_type m);
      mode_type   md;
      logic [7:0] st;
      logic [7:0] d0;
      logic [3:0] ch;
      m = '0;
      m.port = p;
      if (int'(p) >= NUM_PORTS_DEF) return 1'b0;
      md = port_mode[p];
      st = port_status[p];
      ch = port_chan[p];
      d0 = port_first[p];

      if (b[7]) begin
         if ((b & HI_MASK) == HI_MASK) begin
            case (b) inside
               ST_QFRAME: return 1'b0;
               ST_SONG_POS, ST_SONG_SEL, ST_SYSEX: begin
                  port_chan[p]   = '0;
                  port_status[p] = b;
                  port_mode[p]   = (b == ST_SYSEX) ? MODE_SX0 : MODE_DATA0;
                  return 1'b0;
               end
               ST_TUNE, RT_CLOCK, RT_START, RT_CONT, RT_STOP, RT_SENSE, RT_RESET: begin
                  if (b == RT_RESET) clear_port(p);
                  m.len    = LEN_1;
                  m.status = b;
                  return 1'b1;
               end
               ST_EOX: begin
                  port_mode[p] = MODE_IDLE;
                  if (md == MODE_SX1) begin
                     m.len = LEN_3; m.status = st; m.data0 = d0; m.data1 = ST_EOX;
                  end else if (md == MODE_SX0) begin
                     m.len = LEN_2; m.status = st; m.data0 = ST_EOX;
                  end else begin
                     m.len = LEN_1; m.status = ST_EOX;
                  end
                  return 1'b1;
               end
               default: begin
                  clear_port(p);
                  return 1'b0;
               end
            endcase
         end
         // channel status; inside SysEx it closes the dump with a lone EOX
         port_chan[p]   = b[3:0];
         port_status[p] = b & HI_MASK;
         port_mode[p]   = MODE_DATA0;
         if (md == MODE_SX0 || md == MODE_SX1) begin
            m.len    = LEN_1;
            m.status = ST_EOX;
            return 1'b1;
         end
         return 1'b0;
      end

      case (md)
         MODE_DATA0: begin
            port_first[p] = b;
            if (st == ST_SONG_SEL) begin
               clear_port(p);
               m.len = LEN_2; m.status = ST_SONG_SEL; m.data0 = b;
               return 1'b1;
            end
            if (st == ST_PROG || st == ST_CHAN_AT) begin
               m.len = LEN_2; m.status = st | ch; m.data0 = b;
               return 1'b1;
            end
            port_mode[p] = MODE_DATA1;
            return 1'b0;
         end
         MODE_DATA1: begin
            if (st == ST_SONG_POS) begin
               clear_port(p);
               m.len = LEN_3; m.status = ST_SONG_POS; m.data0 = d0; m.data1 = b;
               return 1'b1;
            end
            port_mode[p] = MODE_DATA0;
            m.len   = LEN_3;
            m.data0 = d0;
            case (st) inside
               ST_NOTE_ON: begin
                  // zero velocity turns into a release
                  if (b == 8'h00) begin
                     m.status = ST_NOTE_OFF | ch; m.data1 = VEL_RELEASE;
                  end else begin
                     m.status = ST_NOTE_ON | ch; m.data1 = b;
                  end
                  return 1'b1;
               end
               ST_NOTE_OFF, ST_POLY_AT, ST_CTRL, ST_BEND: begin
                  m.status = st | ch; m.data1 = b;
                  return 1'b1;
               end
               default: return 1'b0;
            endcase
         end
         MODE_SX0: begin
            port_first[p] = b;
            port_mode[p]  = MODE_SX1;
            return 1'b0;
         end
         MODE_SX1: begin
            port_mode[p] = MODE_IDLE;
            m.len = LEN_3; m.status = st; m.data0 = d0; m.data1 = b;
            return 1'b1;
         end
         default: begin
            // stray data byte starts a SysEx continuation chunk
            port_status[p] = b;
            port_mode[p]   = MODE_SX0;
            return 1'b0;
         end
      endcase
   endfunction

   // One byte transfer on the input channel; valid stays high afterwards
   task automatic offer_byte(input logic [PORT_W-1:0] p, input logic [7:0] b);
      int      gap;
      msg_type m;
      gap = src_fast ? 0 : draw_gap();
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid   <= 1'b1;
      req_chan.port    <= p;
      req_chan.rx_byte <= b;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      if (parse_byte(p, b, m)) pending_msgs.push_back(m);
      bytes_sent++;
   endtask

   // Realtime bytes may drop in anywhere in a stream
   task automatic send_in_stream(input logic [PORT_W-1:0] p, input logic [7:0] b);
      if ($urandom_range(0, 11) == 0) offer_byte(p, RT_CODES[$urandom_range(0, 4)]);
      offer_byte(p, b);
   endtask

   function automatic logic [7:0] rand_data();
      case ($urandom_range(0, 7))
         0: return 8'h00;
         1: return 8'h7F;
         default: return 8'($urandom_range(0, 127));
      endcase
   endfunction

   // Receiver: random stalls, plus a long hold-off on request
   initial begin
      int stall;
      rsp_chan.ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         stall = sink_fast ? 0 : draw_gap();
         if (sink_hold_cycles > 0) begin
            stall = sink_hold_cycles;
            sink_hold_cycles = 0;
         end
         if (stall > 0) begin
            rsp_chan.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_chan.ready <= 1'b1;
         @(posedge clock);
         while (!rsp_chan.valid) @(posedge clock);
      end
   end

   function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
      if (want !== got) begin
         $error("%s: expected %0h, got %0h", name, want, got);
         mismatch_count++;
      end
   endfunction

   // Compare each message transfer against the oldest expectation
   always @(posedge clock) begin
      msg_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (pending_msgs.size() == 0) begin
            $error("unexpected message: port %0d status %0h",
                   rsp_chan.msg_port, rsp_chan.msg_status);
            mismatch_count++;
         end else begin
            want = pending_msgs.pop_front();
            check_field("msg_port", 8'(want.port), 8'(rsp_chan.msg_port));
            check_field("msg_len", 8'(want.len), 8'(rsp_chan.msg_len));
            check_field("msg_status", want.status, rsp_chan.msg_status);
            check_field("msg_data0", want.data0, rsp_chan.msg_data0);
            check_field("msg_data1", want.data1, rsp_chan.msg_data1);
         end
      end
   end

   // Voice messages with running status and the zero-velocity release
   task automatic test_channel_messages();
      offer_byte(0, ST_NOTE_ON | 8'h0);
      offer_byte(0, 8'h3C);
      offer_byte(0, 8'h7F);
      offer_byte(0, 8'h3C);
      offer_byte(0, 8'h00);
      offer_byte(0, ST_PROG | 8'hF);
      offer_byte(0, 8'h00);
      offer_byte(0, ST_BEND | 8'h5);
      offer_byte(0, 8'h7F);
      offer_byte(0, 8'h00);
   endtask

   // System common, realtime and undefined system bytes
   task automatic test_system_messages();
      offer_byte(7, ST_SONG_POS);
      offer_byte(7, 8'h01);
      offer_byte(7, 8'h7F);
      offer_byte(7, ST_SONG_SEL);
      offer_byte(7, 8'h7F);
      offer_byte(7, ST_TUNE);
      offer_byte(7, ST_QFRAME);
      offer_byte(7, UNDEF_CODES[2]);
      offer_byte(7, RT_RESET);
   endtask

   // SysEx chunking, channel status inside SysEx and a stray end byte
   task automatic test_sysex_chunks();
      offer_byte(3, ST_SYSEX);
      offer_byte(3, 8'h01);
      offer_byte(3, 8'h02);
      offer_byte(3, 8'h03);
      offer_byte(3, ST_EOX);
      offer_byte(3, ST_SYSEX);
      offer_byte(3, ST_NOTE_OFF | 8'h1);
      offer_byte(3, ST_EOX);
   endtask

   // Hold the receiver off while bytes keep coming, so the input stalls
   task automatic test_backpressure();
      src_fast = 1;
      sink_fast = 0;
      sink_hold_cycles = 300;
      repeat (40) offer_byte(PORT_W'($urandom_range(0, 7)), RT_CODES[$urandom_range(0, 4)]);
      src_fast = 0;
   endtask

   // One well-formed message with random content, or some noise
   task automatic send_random_message();
      logic [PORT_W-1:0] p;
      logic [7:0]        st;
      int                kind;
      int                n;
      p = PORT_W'($urandom_range(0, 7));
      kind = $urandom_range(0, 19);
      if (kind <= 8) begin
         st = CHAN_CODES[$urandom_range(0, 6)] | 8'($urandom_range(0, 15));
         send_in_stream(p, st);
         repeat ($urandom_range(1, 3)) begin
            send_in_stream(p, rand_data());
            if ((st & HI_MASK) != ST_PROG && (st & HI_MASK) != ST_CHAN_AT) begin
               if ((st & HI_MASK) == ST_NOTE_ON && $urandom_range(0, 3) == 0)
                  send_in_stream(p, 8'h00);
               else
                  send_in_stream(p, rand_data());
            end
         end
      end else if (kind == 9) begin
         send_in_stream(p, ST_SONG_POS);
         send_in_stream(p, rand_data());
         send_in_stream(p, rand_data());
      end else if (kind == 10) begin
         send_in_stream(p, ST_SONG_SEL);
         send_in_stream(p, rand_data());
      end else if (kind <= 13) begin
         send_in_stream(p, ST_SYSEX);
         n = $urandom_range(0, 7);
         repeat (n) send_in_stream(p, rand_data());
         case ($urandom_range(0, 7))
            0: begin
               send_in_stream(p, CHAN_CODES[$urandom_range(0, 6)] | 8'($urandom_range(0, 15)));
               send_in_stream(p, rand_data());
            end
            1: ;
            default: send_in_stream(p, ST_EOX);
         endcase
      end else if (kind == 14) begin
         offer_byte(p, $urandom_range(0, 1) ? ST_TUNE : ST_QFRAME);
      end else if (kind == 15) begin
         offer_byte(p, UNDEF_CODES[$urandom_range(0, 3)]);
      end else if (kind == 16) begin
         offer_byte(p, RT_RESET);
      end else begin
         repeat ($urandom_range(1, 3))
            offer_byte(PORT_W'($urandom_range(0, 7)), 8'($urandom_range(0, 255)));
      end
   endtask

   task automatic test_random_traffic(int n_bytes);
      int target;
      target = bytes_sent + n_bytes;
      while (bytes_sent < target) begin
         // occasional stretches without idling on either side
         if ($urandom_range(0, 39) == 0) begin
            src_fast  = 1'($urandom_range(0, 1));
            sink_fast = 1'($urandom_range(0, 1));
         end
         send_random_message();
      end
      src_fast  = 0;
      sink_fast = 0;
   endtask

   // Stimulus sequence
   initial begin
      for (int i = 0; i < MAX_PORTS; i++) begin
         clear_port(i);
         port_first[i] = '0;
      end
      reset            <= 1'b1;
      req_chan.valid   <= 1'b0;
      req_chan.port    <= '0;
      req_chan.rx_byte <= '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      test_channel_messages();
      test_system_messages();
      test_sysex_chunks();
      test_backpressure();
      test_random_traffic(1500);

      req_chan.valid <= 1'b0;
      while (pending_msgs.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && pending_msgs.size() == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

   // Watchdog
   initial begin
      #(5_000_000);
      $display("Mismatches found");
      $finish;
   end

endmodule
